[rtl/core/srfa_pkg.sv]
// ----------------------------------------------------------------------------
// srfa_pkg
// Shared widths and constants for the swing rotation block.
// ----------------------------------------------------------------------------
package srfa_pkg;

   localparam int unsigned DATA_W    = 16;
   localparam int unsigned THR_W     = 15;
   localparam int unsigned DIV_BITS  = 15;
   localparam int unsigned DEN_W     = 33;
   localparam int unsigned REM_W     = 34;
   localparam int unsigned NUM_W     = 35;
   localparam int unsigned LANES     = 9;

   localparam logic signed [16:0] Q_ONE = 17'sd16384;
   localparam logic [THR_W-1:0]   THR_RESET = 15'd16;

endpackage

[rtl/core/srfa_if.sv]
// ----------------------------------------------------------------------------
// srfa interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface srfa_req_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [srfa_pkg::DATA_W-1:0]        col_x;
   logic signed [srfa_pkg::DATA_W-1:0]        col_y;
   logic signed [srfa_pkg::DATA_W-1:0]        col_z;
   modport source (output valid, col_x, col_y, col_z, input ready);
   modport sink   (input valid, col_x, col_y, col_z, output ready);
endinterface

interface srfa_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [srfa_pkg::DATA_W-1:0]        m00, m01, m02, m10, m11, m12, m20, m21, m22;
   logic                                      singular;
   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, singular,
                   input ready);
   modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, singular,
                   output ready);
endinterface

interface srfa_csr_if;
   logic                                      valid;
   logic                                      ready;
   logic [srfa_pkg::THR_W-1:0]                data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

[rtl/core/srfa_div_lane.sv]
// ----------------------------------------------------------------------------
// srfa_div_lane
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module srfa_div_lane (
   input  logic                            clock,
   input  logic                            en,
   input  logic [srfa_pkg::REM_W-1:0]      start_rem,
   input  logic [srfa_pkg::DEN_W-1:0]      start_den,
   input  logic                            start_neg,
   output logic [srfa_pkg::DIV_BITS-1:0]   quo,
   output logic                            neg
);
   localparam int unsigned NSTG = srfa_pkg::DIV_BITS;

   logic [srfa_pkg::REM_W-1:0]    rem_ff [NSTG+1];
   logic [srfa_pkg::DEN_W-1:0]    den_ff [NSTG+1];
   logic                          neg_ff [NSTG+1];
   logic [NSTG-1:0]               quo_ff [NSTG+1];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= start_rem;
         den_ff[0] <= start_den;
         neg_ff[0] <= start_neg;
         quo_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < NSTG; i++) begin : g_stage
      logic [srfa_pkg::REM_W:0]   trial;
      logic [srfa_pkg::REM_W:0]   dsr;
      logic                       ge;
      logic [srfa_pkg::REM_W-1:0] rem_in;
      logic [srfa_pkg::REM_W:0]   diff;

      always_comb begin
         trial  = {rem_ff[i], den_ff[i][NSTG-1-i]};
         dsr    = {1'b0, den_ff[i], 1'b0};
         ge     = (trial >= dsr);
         diff   = trial - dsr;
         rem_in = ge ? diff[srfa_pkg::REM_W-1:0] : trial[srfa_pkg::REM_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i+1] <= rem_in;
            den_ff[i+1] <= den_ff[i];
            neg_ff[i+1] <= neg_ff[i];
            quo_ff[i+1] <= {quo_ff[i][NSTG-2:0], ge};
         end
      end
   end

   assign quo = quo_ff[NSTG];
   assign neg = neg_ff[NSTG];
endmodule

[rtl/core/swing_rotation_from_axis.sv]
// ----------------------------------------------------------------------------
// swing_rotation_from_axis
// Swing rotation matrix from the third column of a rotation, Q2.14.
// ----------------------------------------------------------------------------
// One transaction is accepted per cycle while the response is not stalled;
// the twenty register stages from acceptance to the offered result are input
// capture, products, sums, dividend set-up, fifteen quotient stages in each
// of the nine entry lanes and the output register.
// A stalled response holds the whole pipeline. The threshold register is
// written through csr_chan and always accepted.
module swing_rotation_from_axis (
   input  logic       clock,
   input  logic       reset,
   srfa_req_if.sink   req_chan,
   srfa_rsp_if.source rsp_chan,
   srfa_csr_if.sink   csr_chan
);
   localparam int unsigned NSTG = srfa_pkg::DIV_BITS;
   localparam int unsigned NL   = srfa_pkg::LANES;

   logic                               en;
   logic [srfa_pkg::THR_W-1:0]         thr_ff;

   logic                               v1_ff, v2_ff, v3_ff;
   logic                               sg1_ff, sg2_ff, sg3_ff;
   logic signed [15:0]                 x1_ff, y1_ff;
   logic signed [16:0]                 s1_ff;
   logic signed [16:0]                 s_in;

   logic signed [33:0]                 ss_ff, xx_ff, yy_ff, xy_ff, xs_ff, ys_ff;
   logic signed [srfa_pkg::NUM_W-1:0]  num_ff [NL];
   logic [srfa_pkg::DEN_W-1:0]         den_ff;
   logic signed [srfa_pkg::NUM_W-1:0]  num_in [NL];
   logic signed [srfa_pkg::NUM_W-1:0]  den_in;

   logic                               vd_ff [NSTG+1];
   logic                               sgd_ff [NSTG+1];

   logic [NSTG-1:0]                    quo [NL];
   logic                               qneg [NL];
   logic signed [15:0]                 ent_in [NL];
   logic signed [15:0]                 ent_ff [NL];
   logic                               out_v_ff, out_sg_ff;

   assign en             = !out_v_ff || rsp_chan.ready;
   assign req_chan.ready = en;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= srfa_pkg::THR_RESET;
      end else if (csr_chan.valid) begin
         thr_ff <= csr_chan.data;
      end
   end

   assign s_in = 17'(req_chan.col_z) + srfa_pkg::Q_ONE;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff  <= req_chan.col_x;
         y1_ff  <= req_chan.col_y;
         s1_ff  <= s_in;
         sg1_ff <= (s_in <= $signed({2'b00, thr_ff}));
         ss_ff  <= 34'(s1_ff * s1_ff);
         xx_ff  <= 34'(x1_ff * x1_ff);
         yy_ff  <= 34'(y1_ff * y1_ff);
         xy_ff  <= 34'(x1_ff * y1_ff);
         xs_ff  <= 34'(x1_ff * s1_ff);
         ys_ff  <= 34'(y1_ff * s1_ff);
         sg2_ff <= sg1_ff;
         sg3_ff <= sg2_ff;
         den_ff <= den_in[srfa_pkg::DEN_W-1:0];
         for (int k = 0; k < NL; k++) begin
            num_ff[k] <= num_in[k];
         end
      end
   end

   always_comb begin
      den_in    = 35'(ss_ff) + 35'(xx_ff) + 35'(yy_ff);
      num_in[0] = 35'(ss_ff) + 35'(yy_ff) - 35'(xx_ff);
      num_in[1] = -(35'(xy_ff) <<< 1);
      num_in[2] =  (35'(xs_ff) <<< 1);
      num_in[3] = -(35'(xy_ff) <<< 1);
      num_in[4] = 35'(ss_ff) - 35'(yy_ff) + 35'(xx_ff);
      num_in[5] =  (35'(ys_ff) <<< 1);
      num_in[6] = -(35'(xs_ff) <<< 1);
      num_in[7] = -(35'(ys_ff) <<< 1);
      num_in[8] = 35'(ss_ff) - 35'(yy_ff) - 35'(xx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NSTG; k++) begin
            vd_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vd_ff[0] <= v3_ff;
         for (int k = 1; k <= NSTG; k++) begin
            vd_ff[k] <= vd_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sgd_ff[0] <= sg3_ff;
         for (int k = 1; k <= NSTG; k++) begin
            sgd_ff[k] <= sgd_ff[k-1];
         end
      end
   end

   for (genvar l = 0; l < NL; l++) begin : g_lane
      logic                              ln_neg;
      logic [srfa_pkg::NUM_W-1:0]        ln_abs;
      logic [srfa_pkg::REM_W-1:0]        ln_rem;

      always_comb begin
         ln_neg = num_ff[l][srfa_pkg::NUM_W-1];
         ln_abs = ln_neg ? 35'(-num_ff[l]) : 35'(num_ff[l]);
         ln_rem = ln_abs[srfa_pkg::REM_W-1:0]
                + 34'(den_ff[srfa_pkg::DEN_W-1:NSTG]);
      end

      srfa_div_lane u_div (
         .clock     (clock),
         .en        (en),
         .start_rem (ln_rem),
         .start_den (den_ff),
         .start_neg (ln_neg),
         .quo       (quo[l]),
         .neg       (qneg[l])
      );

      always_comb begin
         if (sgd_ff[NSTG]) begin
            ent_in[l] = '0;
         end else if (qneg[l]) begin
            ent_in[l] = -$signed({1'b0, quo[l]});
         end else begin
            ent_in[l] = $signed({1'b0, quo[l]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= vd_ff[NSTG];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_sg_ff <= sgd_ff[NSTG];
         for (int k = 0; k < NL; k++) begin
            ent_ff[k] <= ent_in[k];
         end
      end
   end

   assign rsp_chan.valid    = out_v_ff;
   assign rsp_chan.singular = out_sg_ff;
   assign rsp_chan.m00      = ent_ff[0];
   assign rsp_chan.m01      = ent_ff[1];
   assign rsp_chan.m02      = ent_ff[2];
   assign rsp_chan.m10      = ent_ff[3];
   assign rsp_chan.m11      = ent_ff[4];
   assign rsp_chan.m12      = ent_ff[5];
   assign rsp_chan.m20      = ent_ff[6];
   assign rsp_chan.m21      = ent_ff[7];
   assign rsp_chan.m22      = ent_ff[8];
endmodule

[rtl/core/srfa_checker.sv]
// ----------------------------------------------------------------------------
// srfa_assertions
// Port-level checks on the swing rotation block, bound to its top level.
// ----------------------------------------------------------------------------
module srfa_assertions (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               csr_ready,
   input logic               singular,
   input logic signed [15:0] m00,
   input logic signed [15:0] m11,
   input logic signed [15:0] m22,
   input logic signed [15:0] m01
);
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && singular |-> m00 == 16'sd0 && m11 == 16'sd0 && m22 == 16'sd0
                                && m01 == 16'sd0)
      else $error("singular result with non-zero entries");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !singular |-> m00 <= 16'sd16384 && m00 >= -16'sd16384
                                 && m22 <= 16'sd16384 && m22 >= -16'sd16384)
      else $error("rotation entry beyond unit magnitude");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(m00) && $stable(singular))
      else $error("stalled response changed");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("register channel not ready");
endmodule

bind swing_rotation_from_axis srfa_assertions u_srfa_assertions (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .csr_ready (csr_chan.ready),
   .singular  (rsp_chan.singular),
   .m00       (rsp_chan.m00),
   .m11       (rsp_chan.m11),
   .m22       (rsp_chan.m22),
   .m01       (rsp_chan.m01)
);
